// ===== design/nss_pkg.sv =====
// Shared widths, codes and defaults of the night sleep summary block.
// No dependencies; the interfaces, the top level and the bench import this package.
`default_nettype none
package nss_pkg;
  // Field widths of the item channels and the configuration port
  localparam int VERDICT_W  = 2;
  localparam int HR_W       = 16;
  localparam int SAMPLE_W   = 16;
  localparam int ACT_W      = 16;
  localparam int METRIC_W   = 5;
  localparam int IDX_W      = 4;
  localparam int VALUE_W    = 21;
  localparam int ONSET_W    = 7;
  localparam int FLOOR_W    = 16;
  localparam int SECS_W     = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Default sizes of the epoch store and of the awakening list
  localparam int DEF_MAX_EPOCHS = 1024;
  localparam int DEF_MAX_LISTED = 16;

  // Scale factors of the rate and percent metrics
  localparam int RATE_SCALE = 10;
  localparam int PCT_SCALE  = 100;

  // Epoch verdicts
  localparam logic [VERDICT_W-1:0] V_SLEEP    = 2'd0;
  localparam logic [VERDICT_W-1:0] V_WAKE     = 2'd1;
  localparam logic [VERDICT_W-1:0] V_UNSCORED = 2'd2;
  localparam logic [VERDICT_W-1:0] V_SPARE    = 2'd3;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_ONSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SECS  = 2'd2;
  localparam logic [ONSET_W-1:0]   ONSET_RESET = 7'd10;
  localparam logic [FLOOR_W-1:0]   FLOOR_RESET = 16'd0;
  localparam logic [SECS_W-1:0]    SECS_RESET  = 12'd60;

  // Metric codes
  localparam logic [METRIC_W-1:0] M_EPOCHS     = 5'd0;
  localparam logic [METRIC_W-1:0] M_UNSCORED   = 5'd1;
  localparam logic [METRIC_W-1:0] M_HR_COUNT   = 5'd2;
  localparam logic [METRIC_W-1:0] M_HR_MIN     = 5'd3;
  localparam logic [METRIC_W-1:0] M_HR_MIN_EP  = 5'd4;
  localparam logic [METRIC_W-1:0] M_HR_MEAN    = 5'd5;
  localparam logic [METRIC_W-1:0] M_SMP_MIN    = 5'd6;
  localparam logic [METRIC_W-1:0] M_SMP_MEDIAN = 5'd7;
  localparam logic [METRIC_W-1:0] M_SMP_RATE   = 5'd8;
  localparam logic [METRIC_W-1:0] M_IN_BED     = 5'd9;
  localparam logic [METRIC_W-1:0] M_ONSET      = 5'd10;
  localparam logic [METRIC_W-1:0] M_FINAL_WAKE = 5'd11;
  localparam logic [METRIC_W-1:0] M_LATENCY    = 5'd12;
  localparam logic [METRIC_W-1:0] M_SLEEP      = 5'd13;
  localparam logic [METRIC_W-1:0] M_WASO       = 5'd14;
  localparam logic [METRIC_W-1:0] M_AWAKE      = 5'd15;
  localparam logic [METRIC_W-1:0] M_LISTED     = 5'd16;
  localparam logic [METRIC_W-1:0] M_STILL      = 5'd17;
  localparam logic [METRIC_W-1:0] M_MOVE_PCT   = 5'd18;
  localparam logic [METRIC_W-1:0] M_EFFICIENCY = 5'd19;
  localparam logic [METRIC_W-1:0] M_ENTRY      = 5'd20;

  localparam logic [VALUE_W-1:0] ABSENT = '1;
endpackage
`default_nettype wire

// ===== design/nss_if.sv =====
// Item channel interfaces of the night sleep summary block.
// Depends on nss_pkg for the field widths.
`default_nettype none
interface nss_in_if import nss_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [VERDICT_W-1:0]        verdict;
  logic signed [HR_W-1:0]      hr_tenths;
  logic [SAMPLE_W-1:0]         sample_count;
  logic [ACT_W-1:0]            activity_count;
  logic                        sleep_allowed;
  logic                        last_epoch;

  modport source (output valid, verdict, hr_tenths, sample_count, activity_count,
                  sleep_allowed, last_epoch, input ready);
  modport sink (input valid, verdict, hr_tenths, sample_count, activity_count,
                sleep_allowed, last_epoch, output ready);
endinterface

interface nss_out_if import nss_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [METRIC_W-1:0]         metric;
  logic [IDX_W-1:0]            entry_index;
  logic signed [VALUE_W-1:0]   value;
  logic                        final_result;

  modport source (output valid, metric, entry_index, value, final_result, input ready);
  modport sink (input valid, metric, entry_index, value, final_result, output ready);
endinterface
`default_nettype wire

// ===== design/nss_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module nss_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  wire logic                                clk,
  input  wire logic                                we,
  input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
  input  wire logic [W-1:0]                        wdata,
  input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
  output      logic [W-1:0]                        rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== design/nss_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by the summary.
// No dependencies.
`default_nettype none
module nss_div #(
  parameter int DW = 20,
  parameter int VW = 12
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output      logic          done,
  output      logic [DW-1:0] quotient
);
  localparam int CNTW = $clog2(DW + 1);

  logic [CNTW-1:0] cnt_r;
  logic [VW-1:0]   rem_r;
  logic [VW-1:0]   dvs_r;
  logic [VW:0]     trial;

  assign trial = {rem_r, quotient[DW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt_r    <= CNTW'(DW);
        rem_r    <= '0;
        dvs_r    <= divisor;
        quotient <= dividend;
      end else if (cnt_r != '0) begin
        // shift in one dividend bit and try to subtract
        if (trial >= {1'b0, dvs_r}) begin
          rem_r    <= VW'(trial - {1'b0, dvs_r});
          quotient <= {quotient[DW-2:0], 1'b1};
        end else begin
          rem_r    <= trial[VW-1:0];
          quotient <= {quotient[DW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== design/night_sleep_summary.sv =====
// Top level of the night sleep summary block.
// Depends on nss_pkg, nss_if, nss_ram and nss_div.
//
// The block loads one night of scored epochs, one item per cycle while
// in_ch.ready is high, into an epoch memory (verdict, moving bit and sample
// count per epoch) while it keeps running totals of unscorable epochs and
// heart rate. The item marked last_epoch starts the summary and in_ch.ready
// stays low until the last result has been handed to the output register.
// One forward pass over the epoch memory finds the sample minimum, onset and
// final wake, sixteen passes select the median sample count one bit at a
// time, one pass over the onset span counts the sleep metrics, and one
// restoring divider of width DW (26 bits by default) computes the heart rate
// mean, the sample rate and both percentages in turn. The memory read port
// sets the pass length. Results leave through a registered output stage;
// twenty fixed metrics come first, then one entry per listed awakening, the
// last result carrying final_result. Epochs beyond MAX_EPOCHS are dropped.
// Configuration writes take effect at once and are meant for idle time only.
`default_nettype none
module night_sleep_summary import nss_pkg::*; #(
  parameter int MAX_EPOCHS = DEF_MAX_EPOCHS,
  parameter int MAX_LISTED = DEF_MAX_LISTED
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  nss_in_if.sink                     in_ch,
  nss_out_if.source                  out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);
  localparam int CW  = $clog2(MAX_EPOCHS + 1);
  localparam int AW  = $clog2(MAX_EPOCHS);
  localparam int LW  = $clog2(MAX_LISTED + 1);
  localparam int LAW = (MAX_LISTED > 1) ? $clog2(MAX_LISTED) : 1;
  localparam int HSW = CW + HR_W - 1;
  localparam int DW  = (HSW > 20) ? HSW : 20;
  localparam int DVW = (CW > SECS_W) ? CW : SECS_W;
  localparam int EW  = VERDICT_W + 1 + SAMPLE_W;
  localparam int QW  = VALUE_W - 1;
  localparam int TW  = CW + ONSET_W;
  localparam int PW  = CW + 7;

  typedef enum logic [7:0] {
    S_LOAD  = 8'b00000001,
    S_SCAN  = 8'b00000010,
    S_RADIX = 8'b00000100,
    S_METR  = 8'b00001000,
    S_DIV   = 8'b00010000,
    S_EMIT  = 8'b00100000,
    S_LREAD = 8'b01000000,
    S_LIST  = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [ONSET_W-1:0] onset_cfg_r, onset_cfg_nxt;
  logic [FLOOR_W-1:0] floor_r, floor_nxt;
  logic [SECS_W-1:0]  secs_r, secs_nxt;

  // night totals
  logic [CW-1:0]          n_r, n_nxt, unsc_r, unsc_nxt, hc_r, hc_nxt;
  logic [HSW-1:0]         hsum_r, hsum_nxt;
  logic signed [HR_W-1:0] hmin_r, hmin_nxt;
  logic [AW-1:0]          hmin_ep_r, hmin_ep_nxt;
  logic                   gate_r, gate_nxt;

  // pass sequencing
  logic [CW-1:0] scan_i_r, scan_i_nxt, scan_end_r, scan_end_nxt, pidx_r, pidx_nxt;
  logic          issue_r, issue_nxt, pv_r, pv_nxt;

  // forward pass
  logic [SAMPLE_W-1:0] smin_r, smin_nxt;
  logic [CW-1:0]       run_r, run_nxt, onset_r, onset_nxt, last_r, last_nxt;
  logic                onset_f_r, onset_f_nxt, last_f_r, last_f_nxt;

  // median selection
  logic [3:0]          rb_r, rb_nxt;
  logic [SAMPLE_W-1:0] prefix_r, prefix_nxt;
  logic [CW-1:0]       k_r, k_nxt, cnt_r, cnt_nxt;

  // onset span pass
  logic [CW-1:0] mv_r, mv_nxt, still_r, still_nxt, sl_r, sl_nxt;
  logic [CW-1:0] waso_r, waso_nxt, awk_r, awk_nxt, wrun_r, wrun_nxt;
  logic [LW-1:0] nl_r, nl_nxt;

  // divisions
  logic [1:0]    div_sel_r, div_sel_nxt;
  logic          div_wait_r, div_wait_nxt;
  logic [QW-1:0] mean_r, mean_nxt, rate_r, rate_nxt, mvp_r, mvp_nxt, eff_r, eff_nxt;

  // result emission
  logic [METRIC_W-1:0] code_r, code_nxt;
  logic [LW-1:0]       li_r, li_nxt;
  logic                out_v_r, out_v_nxt;
  logic [METRIC_W-1:0] out_metric_r, out_metric_nxt;
  logic [IDX_W-1:0]    out_idx_r, out_idx_nxt;
  logic [VALUE_W-1:0]  out_value_r, out_value_nxt;
  logic                out_final_r, out_final_nxt;

  // memories
  logic          ep_we;
  logic [AW-1:0] ep_waddr;
  logic [EW-1:0] ep_wdata, ep_rdata;
  logic          ls_we;
  logic [LAW-1:0] ls_waddr, ls_raddr;
  logic [CW-1:0] ls_rdata;

  // divider
  logic          div_start, div_done;
  logic [DW-1:0] div_a, div_q;
  logic [DVW-1:0] div_b, div_b_raw;

  logic                 in_acc, slot_free, store_ok, met_ok, radix_hit;
  logic [VERDICT_W-1:0] in_vd, rd_v;
  logic                 rd_m;
  logic [SAMPLE_W-1:0]  rd_s, hi_mask;
  logic [CW-1:0]        n_new, run_inc, span, radix_c;
  logic [VALUE_W-1:0]   fixed_value;

  nss_ram #(.W(EW), .D(MAX_EPOCHS)) u_epochs (
    .clk   (clk),
    .we    (ep_we),
    .waddr (ep_waddr),
    .wdata (ep_wdata),
    .raddr (scan_i_r[AW-1:0]),
    .rdata (ep_rdata)
  );

  nss_ram #(.W(CW), .D(MAX_LISTED)) u_listed (
    .clk   (clk),
    .we    (ls_we),
    .waddr (ls_waddr),
    .wdata (wrun_r),
    .raddr (ls_raddr),
    .rdata (ls_rdata)
  );

  nss_div #(.DW(DW), .VW(DVW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  assign in_ch.ready         = (state_r == S_LOAD);
  assign in_acc              = in_ch.valid && in_ch.ready;
  assign out_ch.valid        = out_v_r;
  assign out_ch.metric       = out_metric_r;
  assign out_ch.entry_index  = out_idx_r;
  assign out_ch.value        = out_value_r;
  assign out_ch.final_result = out_final_r;
  assign slot_free           = !out_v_r || out_ch.ready;

  // fold the spare verdict code into unscorable
  assign in_vd    = (in_ch.verdict == V_SPARE) ? V_UNSCORED : in_ch.verdict;
  assign store_ok = (n_r < CW'(MAX_EPOCHS));
  assign n_new    = store_ok ? n_r + 1'b1 : n_r;

  assign ep_we    = in_acc && store_ok;
  assign ep_waddr = n_r[AW-1:0];
  assign ep_wdata = {in_vd, (in_ch.activity_count > floor_r), in_ch.sample_count};

  assign rd_v = ep_rdata[EW-1 -: VERDICT_W];
  assign rd_m = ep_rdata[SAMPLE_W];
  assign rd_s = ep_rdata[SAMPLE_W-1:0];

  assign run_inc = run_r + 1'b1;
  assign span    = last_r - onset_r + 1'b1;
  assign met_ok  = gate_r && (n_r != '0) && onset_f_r && last_f_r && (last_r >= onset_r);

  // bits above the one under selection must equal the prefix found so far
  assign hi_mask   = SAMPLE_W'(17'h1FFFF << (5'(rb_r) + 5'd1));
  assign radix_hit = (((rd_s ^ prefix_r) & hi_mask) == '0) && !rd_s[rb_r];
  assign radix_c   = cnt_r + CW'(radix_hit);

  assign ls_waddr = LAW'(nl_r);
  assign ls_raddr = LAW'(li_r);

  // divider operands, picked by the division in progress
  always_comb begin
    unique case (div_sel_r)
      2'd0: begin
        div_a     = DW'(hsum_r);
        div_b_raw = DVW'(hc_r);
      end
      2'd1: begin
        div_a     = DW'(20'(prefix_r) * 20'(RATE_SCALE));
        div_b_raw = DVW'(secs_r);
      end
      2'd2: begin
        div_a     = DW'(PW'(mv_r) * PW'(PCT_SCALE));
        div_b_raw = DVW'(span);
      end
      default: begin
        div_a     = DW'(PW'(sl_r) * PW'(PCT_SCALE));
        div_b_raw = DVW'(n_r);
      end
    endcase
    // a zero divisor only shows up where the quotient is unused or defined as one
    div_b = (div_b_raw == '0) ? DVW'(1) : div_b_raw;
  end

  assign div_start = (state_r == S_DIV) && !div_wait_r;

  // fixed metric values by code
  always_comb begin
    unique case (code_r)
      M_EPOCHS:     fixed_value = VALUE_W'(n_r);
      M_UNSCORED:   fixed_value = VALUE_W'(unsc_r);
      M_HR_COUNT:   fixed_value = VALUE_W'(hc_r);
      M_HR_MIN:     fixed_value = (hc_r != '0) ? VALUE_W'(hmin_r) : ABSENT;
      M_HR_MIN_EP:  fixed_value = (hc_r != '0) ? VALUE_W'(hmin_ep_r) : ABSENT;
      M_HR_MEAN:    fixed_value = (hc_r != '0) ? VALUE_W'(mean_r) : ABSENT;
      M_SMP_MIN:    fixed_value = (n_r != '0) ? VALUE_W'(smin_r) : ABSENT;
      M_SMP_MEDIAN: fixed_value = (n_r != '0) ? VALUE_W'(prefix_r) : ABSENT;
      M_SMP_RATE:   fixed_value = (n_r != '0) ? VALUE_W'(rate_r) : ABSENT;
      M_IN_BED:     fixed_value = (gate_r && n_r != '0) ? VALUE_W'(n_r) : ABSENT;
      M_ONSET:      fixed_value = (gate_r && n_r != '0 && onset_f_r) ?
                                  VALUE_W'(onset_r) : ABSENT;
      M_FINAL_WAKE: fixed_value = (gate_r && n_r != '0 && last_f_r) ?
                                  VALUE_W'(last_r) : ABSENT;
      M_LATENCY:    fixed_value = met_ok ? VALUE_W'(onset_r) : ABSENT;
      M_SLEEP:      fixed_value = met_ok ? VALUE_W'(sl_r) : ABSENT;
      M_WASO:       fixed_value = met_ok ? VALUE_W'(waso_r) : ABSENT;
      M_AWAKE:      fixed_value = met_ok ? VALUE_W'(awk_r) : ABSENT;
      M_LISTED:     fixed_value = met_ok ? VALUE_W'(nl_r) : ABSENT;
      M_STILL:      fixed_value = met_ok ? VALUE_W'(still_r) : ABSENT;
      M_MOVE_PCT:   fixed_value = met_ok ? VALUE_W'(mvp_r) : ABSENT;
      M_EFFICIENCY: fixed_value = met_ok ? VALUE_W'(eff_r) : ABSENT;
      default:      fixed_value = ABSENT;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    onset_cfg_nxt  = onset_cfg_r;
    floor_nxt      = floor_r;
    secs_nxt       = secs_r;
    n_nxt          = n_r;
    unsc_nxt       = unsc_r;
    hc_nxt         = hc_r;
    hsum_nxt       = hsum_r;
    hmin_nxt       = hmin_r;
    hmin_ep_nxt    = hmin_ep_r;
    gate_nxt       = gate_r;
    scan_i_nxt     = scan_i_r;
    scan_end_nxt   = scan_end_r;
    issue_nxt      = issue_r;
    pv_nxt         = 1'b0;
    pidx_nxt       = pidx_r;
    smin_nxt       = smin_r;
    run_nxt        = run_r;
    onset_nxt      = onset_r;
    onset_f_nxt    = onset_f_r;
    last_nxt       = last_r;
    last_f_nxt     = last_f_r;
    rb_nxt         = rb_r;
    prefix_nxt     = prefix_r;
    k_nxt          = k_r;
    cnt_nxt        = cnt_r;
    mv_nxt         = mv_r;
    still_nxt      = still_r;
    sl_nxt         = sl_r;
    waso_nxt       = waso_r;
    awk_nxt        = awk_r;
    wrun_nxt       = wrun_r;
    nl_nxt         = nl_r;
    div_sel_nxt    = div_sel_r;
    div_wait_nxt   = div_wait_r;
    mean_nxt       = mean_r;
    rate_nxt       = rate_r;
    mvp_nxt        = mvp_r;
    eff_nxt        = eff_r;
    code_nxt       = code_r;
    li_nxt         = li_r;
    out_v_nxt      = out_v_r && !out_ch.ready;
    out_metric_nxt = out_metric_r;
    out_idx_nxt    = out_idx_r;
    out_value_nxt  = out_value_r;
    out_final_nxt  = out_final_r;
    ls_we          = 1'b0;

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_ONSET: onset_cfg_nxt = cfg_wdata[ONSET_W-1:0];
        CFG_FLOOR: floor_nxt     = cfg_wdata[FLOOR_W-1:0];
        CFG_SECS:  secs_nxt      = cfg_wdata[SECS_W-1:0];
        default:   ;
      endcase
    end

    // issue one memory read per cycle while a pass runs
    if ((state_r == S_SCAN || state_r == S_RADIX || state_r == S_METR) && issue_r) begin
      pv_nxt   = 1'b1;
      pidx_nxt = scan_i_r;
      if (scan_i_r == scan_end_r) begin
        issue_nxt = 1'b0;
      end else begin
        scan_i_nxt = scan_i_r + 1'b1;
      end
    end

    unique case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (store_ok) begin
            n_nxt = n_new;
            if (in_vd == V_UNSCORED) begin
              unsc_nxt = unsc_r + 1'b1;
            end
            if (in_ch.hr_tenths > 0) begin
              if (hc_r == '0 || in_ch.hr_tenths < hmin_r) begin
                hmin_nxt    = in_ch.hr_tenths;
                hmin_ep_nxt = n_r[AW-1:0];
              end
              hsum_nxt = hsum_r + HSW'(in_ch.hr_tenths);
              hc_nxt   = hc_r + 1'b1;
            end
          end
          if (in_ch.last_epoch) begin
            // start the summary: clear the pass results of the previous night
            gate_nxt     = in_ch.sleep_allowed;
            onset_f_nxt  = 1'b0;
            last_f_nxt   = 1'b0;
            run_nxt      = '0;
            smin_nxt     = '1;
            prefix_nxt   = '0;
            mv_nxt       = '0;
            still_nxt    = '0;
            sl_nxt       = '0;
            waso_nxt     = '0;
            awk_nxt      = '0;
            wrun_nxt     = '0;
            nl_nxt       = '0;
            div_sel_nxt  = 2'd0;
            div_wait_nxt = 1'b0;
            if (n_new != '0) begin
              scan_i_nxt   = '0;
              scan_end_nxt = n_new - 1'b1;
              issue_nxt    = 1'b1;
              state_nxt    = S_SCAN;
            end else begin
              state_nxt = S_DIV;
            end
          end
        end
      end

      S_SCAN: begin
        if (pv_r) begin
          if (rd_s < smin_r) begin
            smin_nxt = rd_s;
          end
          if (rd_v == V_SLEEP) begin
            last_f_nxt = 1'b1;
            last_nxt   = pidx_r;
            if (!onset_f_r) begin
              run_nxt = run_inc;
              // a zero run length acts as a run of one
              if (TW'(run_inc) >= TW'((onset_cfg_r == '0) ? ONSET_W'(1) : onset_cfg_r)) begin
                onset_f_nxt = 1'b1;
                onset_nxt   = pidx_r - run_r;
              end
            end
          end else begin
            run_nxt = '0;
          end
          if (pidx_r == scan_end_r) begin
            rb_nxt     = 4'd15;
            prefix_nxt = '0;
            k_nxt      = (n_r - 1'b1) >> 1;
            cnt_nxt    = '0;
            scan_i_nxt = '0;
            issue_nxt  = 1'b1;
            state_nxt  = S_RADIX;
          end
        end
      end

      S_RADIX: begin
        if (pv_r) begin
          cnt_nxt = radix_c;
          if (pidx_r == scan_end_r) begin
            // settle one median bit from the count of smaller candidates
            if (k_r >= radix_c) begin
              prefix_nxt = prefix_r | (SAMPLE_W'(1) << rb_r);
              k_nxt      = k_r - radix_c;
            end
            cnt_nxt = '0;
            if (rb_r == 4'd0) begin
              if (met_ok) begin
                scan_i_nxt   = onset_r;
                scan_end_nxt = last_r;
                issue_nxt    = 1'b1;
                state_nxt    = S_METR;
              end else begin
                state_nxt = S_DIV;
              end
            end else begin
              rb_nxt     = rb_r - 1'b1;
              scan_i_nxt = '0;
              issue_nxt  = 1'b1;
            end
          end
        end
      end

      S_METR: begin
        if (pv_r) begin
          if (rd_m) begin
            mv_nxt = mv_r + 1'b1;
          end else begin
            still_nxt = still_r + 1'b1;
          end
          if (rd_v == V_SLEEP) begin
            // a sleep epoch closes an awakening run
            if (wrun_r != '0) begin
              if (nl_r < LW'(MAX_LISTED)) begin
                ls_we  = 1'b1;
                nl_nxt = nl_r + 1'b1;
              end
              awk_nxt  = awk_r + 1'b1;
              wrun_nxt = '0;
            end
            sl_nxt = sl_r + 1'b1;
          end else if (rd_v == V_WAKE) begin
            waso_nxt = waso_r + 1'b1;
            wrun_nxt = wrun_r + 1'b1;
          end else begin
            wrun_nxt = '0;
          end
          if (pidx_r == scan_end_r) begin
            state_nxt = S_DIV;
          end
        end
      end

      S_DIV: begin
        if (!div_wait_r) begin
          div_wait_nxt = 1'b1;
        end else if (div_done) begin
          div_wait_nxt = 1'b0;
          unique case (div_sel_r)
            2'd0:    mean_nxt = div_q[QW-1:0];
            2'd1:    rate_nxt = div_q[QW-1:0];
            2'd2:    mvp_nxt  = div_q[QW-1:0];
            default: eff_nxt  = div_q[QW-1:0];
          endcase
          if (div_sel_r == 2'd3) begin
            code_nxt  = M_EPOCHS;
            state_nxt = S_EMIT;
          end else begin
            div_sel_nxt = div_sel_r + 1'b1;
          end
        end
      end

      S_EMIT: begin
        if (slot_free) begin
          out_v_nxt      = 1'b1;
          out_metric_nxt = code_r;
          out_idx_nxt    = '0;
          out_value_nxt  = fixed_value;
          out_final_nxt  = (code_r == M_EFFICIENCY) && (nl_r == '0);
          if (code_r == M_EFFICIENCY) begin
            li_nxt    = '0;
            state_nxt = (nl_r == '0) ? S_LOAD : S_LREAD;
          end else begin
            code_nxt = code_r + 1'b1;
          end
        end
      end

      S_LREAD: begin
        // wait for the list memory read
        state_nxt = S_LIST;
      end

      S_LIST: begin
        if (slot_free) begin
          out_v_nxt      = 1'b1;
          out_metric_nxt = M_ENTRY;
          out_idx_nxt    = IDX_W'(li_r);
          out_value_nxt  = VALUE_W'(ls_rdata);
          out_final_nxt  = (li_r == nl_r - 1'b1);
          if (li_r == nl_r - 1'b1) begin
            state_nxt = S_LOAD;
          end else begin
            li_nxt    = li_r + 1'b1;
            state_nxt = S_LREAD;
          end
        end
      end

      default: state_nxt = S_LOAD;
    endcase

    // drop the night once the summary is out
    if (state_r != S_LOAD && state_nxt == S_LOAD) begin
      n_nxt       = '0;
      unsc_nxt    = '0;
      hc_nxt      = '0;
      hsum_nxt    = '0;
      hmin_nxt    = '0;
      hmin_ep_nxt = '0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_LOAD;
      onset_cfg_r  <= ONSET_RESET;
      floor_r      <= FLOOR_RESET;
      secs_r       <= SECS_RESET;
      n_r          <= '0;
      unsc_r       <= '0;
      hc_r         <= '0;
      hsum_r       <= '0;
      hmin_r       <= '0;
      hmin_ep_r    <= '0;
      issue_r      <= 1'b0;
      pv_r         <= 1'b0;
      div_wait_r   <= 1'b0;
      out_v_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      onset_cfg_r  <= onset_cfg_nxt;
      floor_r      <= floor_nxt;
      secs_r       <= secs_nxt;
      n_r          <= n_nxt;
      unsc_r       <= unsc_nxt;
      hc_r         <= hc_nxt;
      hsum_r       <= hsum_nxt;
      hmin_r       <= hmin_nxt;
      hmin_ep_r    <= hmin_ep_nxt;
      issue_r      <= issue_nxt;
      pv_r         <= pv_nxt;
      div_wait_r   <= div_wait_nxt;
      out_v_r      <= out_v_nxt;
    end
  end

  // pass and result data
  always_ff @(posedge clk) begin
    gate_r       <= gate_nxt;
    scan_i_r     <= scan_i_nxt;
    scan_end_r   <= scan_end_nxt;
    pidx_r       <= pidx_nxt;
    smin_r       <= smin_nxt;
    run_r        <= run_nxt;
    onset_r      <= onset_nxt;
    onset_f_r    <= onset_f_nxt;
    last_r       <= last_nxt;
    last_f_r     <= last_f_nxt;
    rb_r         <= rb_nxt;
    prefix_r     <= prefix_nxt;
    k_r          <= k_nxt;
    cnt_r        <= cnt_nxt;
    mv_r         <= mv_nxt;
    still_r      <= still_nxt;
    sl_r         <= sl_nxt;
    waso_r       <= waso_nxt;
    awk_r        <= awk_nxt;
    wrun_r       <= wrun_nxt;
    nl_r         <= nl_nxt;
    div_sel_r    <= div_sel_nxt;
    mean_r       <= mean_nxt;
    rate_r       <= rate_nxt;
    mvp_r        <= mvp_nxt;
    eff_r        <= eff_nxt;
    code_r       <= code_nxt;
    li_r         <= li_nxt;
    out_metric_r <= out_metric_nxt;
    out_idx_r    <= out_idx_nxt;
    out_value_r  <= out_value_nxt;
    out_final_r  <= out_final_nxt;
  end
endmodule
`default_nettype wire

// ===== bench/night_sleep_summary_tb.sv =====
// Self-checking bench for night_sleep_summary: epoch nights in, metric items out.
// Depends on nss_pkg and the nss_in_if / nss_out_if interfaces of the design.
`default_nettype none
module night_sleep_summary_tb;
  import nss_pkg::*;

  localparam int NIGHT_CAP  = DEF_MAX_EPOCHS;
  localparam int LIST_CAP   = DEF_MAX_LISTED;
  localparam int IDLE_LIMIT = 80000;

  typedef struct {
    logic [VERDICT_W-1:0]   verdict;
    logic signed [HR_W-1:0] hr;
    logic [SAMPLE_W-1:0]    samples;
    logic [ACT_W-1:0]       activity;
    logic                   gate;
    logic                   last;
  } epoch_t;

  typedef struct {
    logic [METRIC_W-1:0] metric;
    logic [IDX_W-1:0]    idx;
    logic [VALUE_W-1:0]  value;
    logic                fin;
  } metric_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  nss_in_if  in_ch ();
  nss_out_if out_ch ();

  night_sleep_summary dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Pending epochs for the driver and metric items still owed by the block
  epoch_t  epochs_pending[$];
  metric_t metrics_due[$];
  int mismatches = 0;
  bit hold_off = 1'b0;
  bit calm = 1'b0;  // when set, both sides run without gaps

  // Shadow copy of the registers
  int unsigned onset_cfg = ONSET_RESET;
  int unsigned floor_cfg = FLOOR_RESET;
  int unsigned secs_cfg  = SECS_RESET;

  // Shadow copy of the night being loaded
  logic [1:0]  night_verdict[NIGHT_CAP];
  bit          night_moving[NIGHT_CAP];
  int unsigned night_samples[NIGHT_CAP];
  int unsigned night_len, unscored_n, hr_n, hr_sum, hr_min_epoch;
  int          hr_min;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.verdict = '0;
    in_ch.hr_tenths = '0;
    in_ch.sample_count = '0;
    in_ch.activity_count = '0;
    in_ch.sleep_allowed = 1'b0;
    in_ch.last_epoch = 1'b0;
    out_ch.ready = 1'b0;
  end

  // Build the summary of the loaded night and clear it for the next one
  task automatic summarize_night(input bit gate);
    int m[20];
    int unsigned sorted_q[$];
    int unsigned durations[$];
    int onset, last_sleep, run, span;
    int unsigned slept, waso, still, moving, awakenings, wrun;
    metric_t r;
    for (int i = 0; i < 20; i++) m[i] = -1;
    m[M_EPOCHS] = night_len;
    m[M_UNSCORED] = unscored_n;
    m[M_HR_COUNT] = hr_n;
    if (hr_n > 0) begin
      m[M_HR_MIN] = hr_min;
      m[M_HR_MIN_EP] = hr_min_epoch;
      m[M_HR_MEAN] = hr_sum / hr_n;
    end
    if (night_len > 0) begin
      for (int i = 0; i < night_len; i++) sorted_q.push_back(night_samples[i]);
      sorted_q.sort();
      m[M_SMP_MIN] = sorted_q[0];
      m[M_SMP_MEDIAN] = sorted_q[(night_len - 1) / 2];
      m[M_SMP_RATE] = (sorted_q[(night_len - 1) / 2] * 10) / (secs_cfg == 0 ? 1 : secs_cfg);
    end
    if (gate && night_len > 0) begin
      onset = -1;
      last_sleep = -1;
      run = 0;
      m[M_IN_BED] = night_len;
      for (int i = 0; i < night_len; i++) begin
        if (night_verdict[i] == V_SLEEP) begin
          run++;
          if (run >= onset_cfg) begin
            onset = i + 1 - run;
            break;
          end
        end else begin
          run = 0;
        end
      end
      for (int i = night_len - 1; i >= 0; i--) begin
        if (night_verdict[i] == V_SLEEP) begin
          last_sleep = i;
          break;
        end
      end
      m[M_ONSET] = onset;
      m[M_FINAL_WAKE] = last_sleep;
      if (onset >= 0 && last_sleep >= onset) begin
        slept = 0; waso = 0; still = 0; moving = 0; awakenings = 0; wrun = 0;
        span = last_sleep - onset + 1;
        for (int i = onset; i <= last_sleep; i++) begin
          if (night_moving[i]) moving++;
          else still++;
          if (night_verdict[i] == V_SLEEP) begin
            if (wrun > 0) begin
              if (durations.size() < LIST_CAP) durations.push_back(wrun);
              awakenings++;
              wrun = 0;
            end
            slept++;
          end else if (night_verdict[i] == V_WAKE) begin
            waso++;
            wrun++;
          end else begin
            wrun = 0;
          end
        end
        m[M_LATENCY] = onset;
        m[M_SLEEP] = slept;
        m[M_WASO] = waso;
        m[M_AWAKE] = awakenings;
        m[M_LISTED] = durations.size();
        m[M_STILL] = still;
        m[M_MOVE_PCT] = (moving * 100) / span;
        m[M_EFFICIENCY] = (slept * 100) / night_len;
      end
    end
    for (int i = 0; i < 20; i++) begin
      r.metric = METRIC_W'(i);
      r.idx = '0;
      r.value = VALUE_W'(m[i]);
      r.fin = (i == 19) && (durations.size() == 0);
      metrics_due.push_back(r);
    end
    foreach (durations[i]) begin
      r.metric = M_ENTRY;
      r.idx = IDX_W'(i);
      r.value = VALUE_W'(durations[i]);
      r.fin = (i == durations.size() - 1);
      metrics_due.push_back(r);
    end
    night_len = 0; unscored_n = 0; hr_n = 0; hr_sum = 0; hr_min = 0; hr_min_epoch = 0;
  endtask

  // Load one accepted epoch into the shadow night
  task automatic load_epoch(input epoch_t e);
    logic [1:0] v;
    int hr;
    v = (e.verdict == V_SPARE) ? V_UNSCORED : e.verdict;
    hr = e.hr;
    if (night_len < NIGHT_CAP) begin
      night_verdict[night_len] = v;
      night_moving[night_len] = (e.activity > floor_cfg);
      night_samples[night_len] = e.samples;
      if (v == V_UNSCORED) unscored_n++;
      if (hr > 0) begin
        if (hr_n == 0 || hr < hr_min) begin
          hr_min = hr;
          hr_min_epoch = night_len;
        end
        hr_sum += hr;
        hr_n++;
      end
      night_len++;
    end
    if (e.last) summarize_night(e.gate);
  endtask

  // Driver: advance the queue on each accepted item, then draw a gap
  int send_gap = 0;
  always @(posedge clk) begin
    epoch_t e;
    bit drive;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        load_epoch(epochs_pending.pop_front());
        send_gap = calm ? 0 : ($urandom_range(0, 1) ? 0 : $urandom_range(0, 17));
      end
      drive = 1'b0;
      if (send_gap > 0) send_gap--;
      else if (epochs_pending.size() > 0) drive = 1'b1;
      in_ch.valid <= drive;
      if (drive) begin
        e = epochs_pending[0];
        in_ch.verdict <= e.verdict;
        in_ch.hr_tenths <= e.hr;
        in_ch.sample_count <= e.samples;
        in_ch.activity_count <= e.activity;
        in_ch.sleep_allowed <= e.gate;
        in_ch.last_epoch <= e.last;
      end
    end
  end

  // Receiver: stall at random, or hold off entirely while hold_off is set
  int recv_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready)
        recv_gap = calm ? 0 : ($urandom_range(0, 1) ? 0 : $urandom_range(0, 17));
      if (recv_gap > 0) recv_gap--;
      out_ch.ready <= !hold_off && recv_gap == 0;
    end
  end

  // Monitor: compare every result item with the oldest one owed
  always @(posedge clk) begin
    metric_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (metrics_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result item: metric %0d entry %0d value %0d", out_ch.metric,
                   out_ch.entry_index, $signed(out_ch.value));
      end else begin
        want = metrics_due.pop_front();
        if (out_ch.metric !== want.metric || out_ch.entry_index !== want.idx ||
            out_ch.value !== want.value || out_ch.final_result !== want.fin) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: got metric %0d entry %0d value %0d last %0b, want %0d %0d %0d %0b",
                     out_ch.metric, out_ch.entry_index, $signed(out_ch.value),
                     out_ch.final_result, want.metric, want.idx, $signed(want.value),
                     want.fin);
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves on either channel for too long
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
    else quiet++;
    if (quiet >= IDLE_LIMIT) begin
      $display("night_sleep_summary_tb: errors");
      $finish;
    end
  end

  // Hold the receiver off for a long stretch early on, while the first nights
  // are still queued, so the block backs up into its input
  initial begin
    repeat (300) @(posedge clk);
    hold_off = 1'b1;
    repeat (2500) @(posedge clk);
    hold_off = 1'b0;
  end

  task automatic push_epoch(input logic [1:0] v, input int hr, input int s, input int a,
                            input bit g, input bit l);
    epoch_t e;
    e.verdict = v;
    e.hr = HR_W'(hr);
    e.samples = SAMPLE_W'(s);
    e.activity = ACT_W'(a);
    e.gate = g;
    e.last = l;
    epochs_pending.push_back(e);
  endtask

  // Queue one night built from runs: long sleep runs reach onset, with short
  // wake and unscorable runs between them; field values are mostly plausible
  task automatic queue_night(input int len, input bit gate);
    int i, run_len, kind;
    logic [1:0] v;
    i = 0;
    while (i < len) begin
      kind = $urandom_range(0, 19);
      if (kind < 11) begin
        v = V_SLEEP;
        run_len = $urandom_range(1, 2 * onset_cfg + 2);
      end else if (kind < 17) begin
        v = V_WAKE;
        run_len = $urandom_range(1, 4);
      end else begin
        v = $urandom_range(V_UNSCORED, V_SPARE);
        run_len = $urandom_range(1, 2);
      end
      for (int k = 0; k < run_len && i < len; k++, i++) begin
        push_epoch(v,
                   ($urandom_range(0, 9) == 0) ? int'($urandom) :
                   ($urandom_range(0, 9) == 0) ? -$urandom_range(0, 1) :
                   $urandom_range(400, 1500),
                   ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1400, 1600),
                   ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 400),
                   (i == len - 1) ? gate : $urandom_range(0, 1), i == len - 1);
      end
    end
  endtask

  // Fill roughly the given number of epochs with random nights
  task automatic queue_nights(input int budget, input int max_len);
    int len;
    while (budget > 0) begin
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : $urandom_range(4, max_len);
      queue_night(len, $urandom_range(0, 5) != 0);
      budget -= len;
    end
  endtask

  // Wait until every item is taken and every result is in, then let the block settle
  task automatic drain;
    while (epochs_pending.size() > 0 || metrics_due.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(data);
    case (idx)
      CFG_ONSET: onset_cfg = data & 32'h7F;
      CFG_FLOOR: floor_cfg = data & 32'hFFFF;
      CFG_SECS:  secs_cfg  = data & 32'hFFF;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(input int unsigned onset, input int unsigned floor_v,
                          input int unsigned secs);
    write_reg(CFG_ONSET, onset);
    write_reg(CFG_FLOOR, floor_v);
    write_reg(CFG_SECS, secs);
  endtask

  initial begin
    night_len = 0; unscored_n = 0; hr_n = 0; hr_sum = 0; hr_min = 0; hr_min_epoch = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes with the gate closed and a spare verdict
    push_epoch(V_SLEEP, 32767, 65535, 65535, 1, 0);
    push_epoch(V_SPARE, -32768, 0, 0, 0, 0);
    push_epoch(V_WAKE, 1, 1, 1, 0, 1);
    // Directed: single wake epoch, no heart rate and no sleep at all
    push_epoch(V_WAKE, -1, 0, 0, 1, 1);
    // Directed: onset after ten sleep epochs, then wake epochs cut off by an unscorable one, no heart rate
    for (int i = 0; i < 11; i++) push_epoch(V_SLEEP, 0, 1500 + i, i * 50, 1, 0);
    push_epoch(V_WAKE, 0, 900, 3000, 0, 0);
    push_epoch(V_WAKE, -5, 2000, 0, 0, 0);
    push_epoch(V_UNSCORED, 0, 1000, 10, 0, 0);
    push_epoch(V_SLEEP, -1, 1700, 0, 1, 1);
    queue_nights(30, 30);
    drain();

    // Shortest onset run, nothing moves, one-second epochs
    set_regs(1, 65535, 1);
    calm = 1'b1;
    for (int i = 0; i < 20; i++)
      push_epoch(i % 2 ? V_WAKE : V_SLEEP, 600 + i, 1500, 100, 1, i == 19);
    queue_nights(15, 30);
    drain();
    calm = 1'b0;
    queue_nights(15, 30);
    drain();

    // Zero onset run and zero epoch length
    set_regs(0, 0, 0);
    queue_nights(30, 30);
    drain();

    // Long onset run, widest epoch length
    set_regs(64, $urandom_range(0, 500), 4095);
    queue_night(70, 1'b1);
    drain();

    // Register maximum for the onset run
    set_regs(127, 100, 3600);
    queue_nights(15, 40);
    drain();

    if (mismatches == 0) begin
      $display("night_sleep_summary_tb: clean");
    end else begin
      $display("night_sleep_summary_tb: errors");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
design/nss_pkg.sv
design/nss_if.sv
design/nss_ram.sv
design/nss_div.sv
design/night_sleep_summary.sv
bench/night_sleep_summary_tb.sv
